// ===== hdl/hav_pkg.sv =====
// ----------------------------------------------------------------------------
// hav_pkg: shared types and constants for the haversine distance pipeline
// Fixed-point formats, CORDIC arctangent table and rounding helpers.
// ----------------------------------------------------------------------------
package hav_pkg;

  localparam int LAT_W    = 31;
  localparam int LON_W    = 32;
  localparam int RADIUS_W = 24;
  localparam int DIST_W   = 26;

  localparam int CORDIC_STAGES_DEF = 24;
  localparam int CW                = 34;   // CORDIC datapath width
  localparam int SQRT_W            = 31;   // root width of the square roots

  localparam logic [31:0] PI_Q30       = 32'd3373259426;
  localparam logic [31:0] CORDIC_GAIN  = 32'd652032874;
  localparam logic [31:0] QUARTER_TURN = 32'd900000000;
  localparam logic [31:0] HALF_TURN    = 32'd1800000000;
  localparam logic [31:0] FULL_TURN    = 32'd3600000000;
  localparam logic [25:0] DIST_MAX     = 26'd52706193;
  localparam logic [23:0] RADIUS_RESET = 24'd6372798;

  // floor(PI_Q30 * 2^32 / full turn): reciprocal for the angle conversion
  localparam logic [63:0] CONV_M64 = ({32'd0, PI_Q30} << 32) / {32'd0, FULL_TURN};
  localparam logic [31:0] CONV_M   = CONV_M64[31:0];

  typedef logic signed [CW-1:0] cw_t;

  typedef enum logic [1:0] {
    SEL_SIN,
    SEL_COS,
    SEL_ANG
  } cordic_sel_t;

  function automatic logic [31:0] atan_q30(input int unsigned i);
    logic [31:0] v;
    unique case (i)
      0:  v = 32'h3243F6A8;
      1:  v = 32'h1DAC6705;
      2:  v = 32'h0FADBAFC;
      3:  v = 32'h07F56EA6;
      4:  v = 32'h03FEAB76;
      5:  v = 32'h01FFD55B;
      6:  v = 32'h00FFFAAA;
      7:  v = 32'h007FFF55;
      8:  v = 32'h003FFFEA;
      9:  v = 32'h001FFFFD;
      10: v = 32'h000FFFFF;
      11: v = 32'h0007FFFF;
      12: v = 32'h0003FFFF;
      13: v = 32'h0001FFFF;
      14: v = 32'h0000FFFF;
      15: v = 32'h00007FFF;
      16: v = 32'h00003FFF;
      17: v = 32'h00001FFF;
      18: v = 32'h00000FFF;
      19: v = 32'h000007FF;
      20: v = 32'h000003FF;
      21: v = 32'h000001FF;
      22: v = 32'h000000FF;
      23: v = 32'h0000007F;
      24: v = 32'h0000003F;
      25: v = 32'h0000001F;
      26: v = 32'h0000000F;
      27: v = 32'h00000008;
      28: v = 32'h00000004;
      29: v = 32'h00000002;
      30: v = 32'h00000001;
      default: v = 32'h00000000;
    endcase
    return v;
  endfunction

  // Q2.30 product rounding: floor((p + 2^29) / 2^30)
  function automatic logic signed [33:0] qround(input logic signed [63:0] p);
    logic signed [63:0] t;
    t = p + 64'sd536870912;
    return 34'(t >>> 30);
  endfunction

endpackage

// ===== hdl/hav_if.sv =====
// ----------------------------------------------------------------------------
// hav_if: word channels of the haversine distance block
// Point pair input, distance output and radius configuration write.
// ----------------------------------------------------------------------------
interface hav_in_if import hav_pkg::*;;
  logic                    valid;
  logic                    ready;
  logic signed [LAT_W-1:0] lat_a;
  logic signed [LON_W-1:0] lon_a;
  logic signed [LAT_W-1:0] lat_b;
  logic signed [LON_W-1:0] lon_b;

  modport source (output valid, lat_a, lon_a, lat_b, lon_b, input ready);
  modport sink   (input valid, lat_a, lon_a, lat_b, lon_b, output ready);
endinterface

interface hav_out_if import hav_pkg::*;;
  logic              valid;
  logic              ready;
  logic [DIST_W-1:0] distance_m;

  modport source (output valid, distance_m, input ready);
  modport sink   (input valid, distance_m, output ready);
endinterface

interface hav_cfg_if import hav_pkg::*;;
  logic                valid;
  logic                ready;
  logic [RADIUS_W-1:0] sphere_radius_m;

  modport source (output valid, sphere_radius_m, input ready);
  modport sink   (input valid, sphere_radius_m, output ready);
endinterface

// ===== hdl/hav_cordic.sv =====
// ----------------------------------------------------------------------------
// hav_cordic: pipelined CORDIC, one iteration per register stage
// Rotation gives sine or cosine of z; vectoring gives atan2(y, x).
// ----------------------------------------------------------------------------
module hav_cordic import hav_pkg::*; #(
  parameter int          STAGES = CORDIC_STAGES_DEF,
  parameter cordic_sel_t SEL    = SEL_SIN
) (
  input  logic clk,
  input  logic en,
  input  cw_t  x_i,
  input  cw_t  y_i,
  input  cw_t  z_i,
  output cw_t  res_o
);

  cw_t x_r [STAGES];
  cw_t y_r [STAGES];
  cw_t z_r [STAGES];

  for (genvar i = 0; i < STAGES; i++) begin : g_iter
    cw_t  xp, yp, zp;
    cw_t  x_nxt, y_nxt, z_nxt;
    cw_t  at;
    logic pos;

    if (i == 0) begin : g_first
      assign xp = x_i;
      assign yp = y_i;
      assign zp = z_i;
    end else begin : g_next
      assign xp = x_r[i-1];
      assign yp = y_r[i-1];
      assign zp = z_r[i-1];
    end

    assign at = cw_t'({2'b00, atan_q30(i)});
    // rotation steers on z, vectoring drives y toward zero
    assign pos = (SEL == SEL_ANG) ? yp[CW-1] : !zp[CW-1];

    always_comb begin
      if (pos) begin
        x_nxt = xp - (yp >>> i);
        y_nxt = yp + (xp >>> i);
        z_nxt = zp - at;
      end else begin
        x_nxt = xp + (yp >>> i);
        y_nxt = yp - (xp >>> i);
        z_nxt = zp + at;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        x_r[i] <= x_nxt;
        y_r[i] <= y_nxt;
        z_r[i] <= z_nxt;
      end
    end
  end

  assign res_o = (SEL == SEL_COS) ? x_r[STAGES-1] :
                 (SEL == SEL_SIN) ? y_r[STAGES-1] : z_r[STAGES-1];

endmodule

// ===== hdl/hav_sqrt.sv =====
// ----------------------------------------------------------------------------
// hav_sqrt: pipelined integer floor square root
// One root bit per register stage, most significant first.
// ----------------------------------------------------------------------------
module hav_sqrt import hav_pkg::*; #(
  parameter int RW = SQRT_W
) (
  input  logic            clk,
  input  logic            en,
  input  logic [2*RW-1:0] n_i,
  output logic [RW-1:0]   root_o
);

  logic [2*RW-1:0] rem_r  [RW];
  logic [RW-1:0]   root_r [RW];

  for (genvar k = 0; k < RW; k++) begin : g_bit
    localparam int B = RW - 1 - k;
    logic [2*RW-1:0] remp, rem_nxt;
    logic [RW-1:0]   rootp, root_nxt;
    logic [2*RW:0]   trial;

    if (k == 0) begin : g_first
      assign remp  = n_i;
      assign rootp = '0;
    end else begin : g_next
      assign remp  = rem_r[k-1];
      assign rootp = root_r[k-1];
    end

    // (root + 2^B)^2 - root^2
    assign trial = ({(RW+1)'(0), rootp} << (B + 1)) + ((2*RW+1)'(1) << (2 * B));

    always_comb begin
      if ({1'b0, remp} >= trial) begin
        rem_nxt  = remp - trial[2*RW-1:0];
        root_nxt = rootp | (RW'(1) << B);
      end else begin
        rem_nxt  = remp;
        root_nxt = rootp;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[k]  <= rem_nxt;
        root_r[k] <= root_nxt;
      end
    end
  end

  assign root_o = root_r[RW-1];

endmodule

// ===== hdl/haversine_distance.sv =====
// ----------------------------------------------------------------------------
// haversine_distance: great-circle distance of two points, whole meters
// Haversine formula over fixed-point CORDIC trig and pipelined square roots.
// ----------------------------------------------------------------------------
//  channel | dir | word
//  in_ch   | in  | lat_a, lon_a, lat_b, lon_b (1e-7 degree, signed)
//  out_ch  | out | distance_m (meters, saturated)
//  cfg_ch  | in  | sphere_radius_m (meters)
//
//  One point pair accepted per cycle unless the output word waits; the depth is
//  set by the two CORDIC chains and the two 31-stage square roots.
//  The whole pipeline advances together; it holds while the output word waits.
//  Reset clears the valid bits and loads the default radius.
// ----------------------------------------------------------------------------
module haversine_distance import hav_pkg::*; #(
  parameter int CORDIC_STAGES = CORDIC_STAGES_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  hav_in_if.sink           in_ch,
  hav_out_if.source        out_ch,
  hav_cfg_if.sink          cfg_ch
);

  localparam int NS  = CORDIC_STAGES;
  localparam int RW  = SQRT_W;
  localparam int LAT = 14 + 2 * NS + 2 * RW;

  logic                en;
  logic [LAT-1:0]      v_r;
  logic                out_valid_r;
  logic [DIST_W-1:0]   out_dist_r;
  logic [RADIUS_W-1:0] radius_r;

  assign en           = !out_valid_r || out_ch.ready;
  assign in_ch.ready  = en;
  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      radius_r <= RADIUS_RESET;
    end else if (cfg_ch.valid) begin
      radius_r <= cfg_ch.sphere_radius_m;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r         <= '0;
      out_valid_r <= 1'b0;
    end else if (en) begin
      v_r         <= {v_r[LAT-2:0], in_ch.valid};
      out_valid_r <= v_r[LAT-1];
    end
  end

  // ---- stage 1: differences and magnitudes ----
  logic signed [31:0] dlat_d, la_d, lb_d;
  logic signed [32:0] dlon_d;
  logic [30:0] dlat_mag_r, la_mag_r, lb_mag_r;
  logic [31:0] dlon_mag_r;
  logic        la_neg_r, lb_neg_r;

  assign dlat_d = 32'(in_ch.lat_b) - 32'(in_ch.lat_a);
  assign dlon_d = 33'(in_ch.lon_b) - 33'(in_ch.lon_a);
  assign la_d   = 32'(in_ch.lat_a);
  assign lb_d   = 32'(in_ch.lat_b);

  always_ff @(posedge clk) begin
    if (en) begin
      dlat_mag_r <= dlat_d[31] ? 31'(-dlat_d) : dlat_d[30:0];
      dlon_mag_r <= dlon_d[32] ? 32'(-dlon_d) : dlon_d[31:0];
      la_mag_r   <= la_d[31] ? 31'(-la_d) : la_d[30:0];
      lb_mag_r   <= lb_d[31] ? 31'(-lb_d) : lb_d[30:0];
      la_neg_r   <= 1'b0;
      lb_neg_r   <= 1'b0;
    end
  end

  // ---- stage 2: fold into half a turn; latitudes into a quarter turn ----
  logic [31:0] a0, a1, a1m, r0, r1, ba, bb, ba2, bb2;
  logic        na, nb;
  logic [30:0] r_s2 [4];
  logic [1:0]  neg_s2;

  always_comb begin
    a0  = {1'b0, dlat_mag_r};
    r0  = (a0 > HALF_TURN) ? FULL_TURN - a0 : a0;
    a1  = dlon_mag_r;
    a1m = (a1 >= FULL_TURN) ? a1 - FULL_TURN : a1;
    r1  = (a1m > HALF_TURN) ? FULL_TURN - a1m : a1m;
    ba  = {1'b0, la_mag_r};
    bb  = {1'b0, lb_mag_r};
    na  = ba > QUARTER_TURN;
    nb  = bb > QUARTER_TURN;
    ba2 = na ? HALF_TURN - ba : ba;
    bb2 = nb ? HALF_TURN - bb : bb;
  end

  // latitudes are doubled so every lane converts against the full turn
  always_ff @(posedge clk) begin
    if (en) begin
      r_s2[0] <= r0[30:0];
      r_s2[1] <= r1[30:0];
      r_s2[2] <= {ba2[29:0], 1'b0};
      r_s2[3] <= {bb2[29:0], 1'b0};
      neg_s2  <= {nb ^ lb_neg_r, na ^ la_neg_r};
    end
  end

  // ---- flags riding beside conversion and CORDIC ----
  logic [1:0] neg_c [4];
  logic [1:0] neg_k [NS];

  always_ff @(posedge clk) begin
    if (en) begin
      neg_c[0] <= neg_s2;
      for (int i = 1; i < 4; i++) neg_c[i] <= neg_c[i-1];
      neg_k[0] <= neg_c[3];
      for (int i = 1; i < NS; i++) neg_k[i] <= neg_k[i-1];
    end
  end

  // ---- lanes: angle conversion (4 stages) and rotation CORDIC ----
  // lane 0: latitude difference, 1: longitude difference, 2/3: latitudes
  cw_t cres [4];

  for (genvar l = 0; l < 4; l++) begin : g_lane
    logic [62:0] pm_r, pp_r, ef_r;
    logic [63:0] pn_r, pn3_r, rem;
    logic [30:0] e_r, e3_r, ang_r;

    assign rem = pn3_r - {1'b0, ef_r};

    always_ff @(posedge clk) begin
      if (en) begin
        pm_r  <= 63'(r_s2[l]) * 63'(CONV_M);
        pp_r  <= 63'(r_s2[l]) * 63'(PI_Q30);
        // estimate is exact or one short
        e_r   <= 31'(({1'b0, pm_r} + 64'h8000_0000) >> 32);
        pn_r  <= {1'b0, pp_r} + {32'd0, HALF_TURN};
        ef_r  <= 63'(e_r) * 63'(FULL_TURN);
        e3_r  <= e_r;
        pn3_r <= pn_r;
        ang_r <= e3_r + 31'(rem >= {32'd0, FULL_TURN});
      end
    end

    hav_cordic #(
      .STAGES (NS),
      .SEL    ((l < 2) ? SEL_SIN : SEL_COS)
    ) u_rot (
      .clk   (clk),
      .en    (en),
      .x_i   (cw_t'({2'b00, CORDIC_GAIN})),
      .y_i   ('0),
      .z_i   (cw_t'({3'b000, ang_r})),
      .res_o (cres[l])
    );
  end

  // ---- F: sign of the cosines beyond a quarter turn ----
  cw_t ca_n, cb_n;
  logic signed [31:0] slat_f, slon_f, ca_f, cb_f;

  assign ca_n = -cres[2];
  assign cb_n = -cres[3];

  always_ff @(posedge clk) begin
    if (en) begin
      slat_f <= cres[0][31:0];
      slon_f <= cres[1][31:0];
      ca_f   <= neg_k[NS-1][0] ? ca_n[31:0] : cres[2][31:0];
      cb_f   <= neg_k[NS-1][1] ? cb_n[31:0] : cres[3][31:0];
    end
  end

  // ---- M1..M4: haversine sum ----
  logic signed [63:0] plat_r, plon_r, pw_r, t_r;
  logic signed [31:0] lath_r, lonh_r, w_r, lath3_r;
  logic signed [33:0] plat_q, plon_q, pw_q, t_q, sum;
  logic [30:0]        sum_r;

  assign plat_q = qround(plat_r);
  assign plon_q = qround(plon_r);
  assign pw_q   = qround(pw_r);
  assign t_q    = qround(t_r);
  assign sum    = 34'(lath3_r) + t_q;

  always_ff @(posedge clk) begin
    if (en) begin
      plat_r  <= slat_f * slat_f;
      plon_r  <= slon_f * slon_f;
      pw_r    <= ca_f * cb_f;
      lath_r  <= plat_q[31:0];
      lonh_r  <= plon_q[31:0];
      w_r     <= pw_q[31:0];
      t_r     <= w_r * lonh_r;
      lath3_r <= lath_r;
      if (sum[33]) begin
        sum_r <= '0;
      end else if (sum > 34'sd1073741824) begin
        sum_r <= 31'h4000_0000;
      end else begin
        sum_r <= sum[30:0];
      end
    end
  end

  // ---- q = sqrt(sum), c = sqrt(1 - q^2) ----
  logic [RW-1:0]   q_root, c_root, q_q1, q_q2;
  logic [RW-1:0]   q_dly [RW];
  logic [2*RW-1:0] qq_r, n2_r;

  hav_sqrt #(.RW(RW)) u_sqrt_q (
    .clk    (clk),
    .en     (en),
    .n_i    ({1'b0, sum_r, 30'd0}),
    .root_o (q_root)
  );

  always_ff @(posedge clk) begin
    if (en) begin
      q_q1     <= q_root;
      qq_r     <= (2*RW)'(q_root) * (2*RW)'(q_root);
      q_q2     <= q_q1;
      n2_r     <= ((2*RW)'(1) << 60) - qq_r;
      q_dly[0] <= q_q2;
      for (int i = 1; i < RW; i++) q_dly[i] <= q_dly[i-1];
    end
  end

  hav_sqrt #(.RW(RW)) u_sqrt_c (
    .clk    (clk),
    .en     (en),
    .n_i    (n2_r),
    .root_o (c_root)
  );

  // ---- arcsine by vectoring ----
  cw_t vres;

  hav_cordic #(
    .STAGES (NS),
    .SEL    (SEL_ANG)
  ) u_vec (
    .clk   (clk),
    .en    (en),
    .x_i   (cw_t'({3'b000, c_root})),
    .y_i   (cw_t'({3'b000, q_dly[RW-1]})),
    .z_i   ('0),
    .res_o (vres)
  );

  // ---- scale by radius, round, saturate ----
  logic [30:0] ang;
  logic [54:0] p_r;
  logic [56:0] dsum;
  logic [26:0] dq;

  assign ang  = vres[CW-1] ? '0 : vres[30:0];
  assign dsum = {1'b0, p_r, 1'b0} + (57'(1) << 29);
  assign dq   = dsum[56:30];

  always_ff @(posedge clk) begin
    if (en) begin
      p_r        <= 55'(ang) * 55'(radius_r);
      out_dist_r <= (dq > 27'(DIST_MAX)) ? DIST_MAX : dq[25:0];
    end
  end

  assign out_ch.valid      = out_valid_r;
  assign out_ch.distance_m = out_dist_r;

endmodule
